@@ src/log_extent_savepoint_tracker_assert.svh @@
// Assertion macros for the log extent savepoint tracker checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef LOG_EXTENT_SAVEPOINT_TRACKER_ASSERT_SVH
`define LOG_EXTENT_SAVEPOINT_TRACKER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define LEST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lest: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define LEST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lest: same-cycle check failed");

`endif

@@ src/lest_pkg.sv @@
// Package for the log extent savepoint tracker: sizes, codes and shared types.
// No dependencies; every other source file but the assertion header imports it.
package lest_pkg;

  localparam int MAX_EXTENTS    = 16;
  localparam int MAX_SAVEPOINTS = 16;
  localparam int SEQ_WIDTH      = 32;

  localparam int EXT_IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int EXT_CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int SP_IDX_W  = (MAX_SAVEPOINTS > 1) ? $clog2(MAX_SAVEPOINTS) : 1;
  localparam int SP_CNT_W  = $clog2(MAX_SAVEPOINTS + 1);

  // Fixed port field widths
  localparam int CMD_W    = 3;
  localparam int SEQ_IN_W = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 4;
  localparam int INUSE_W  = 5;
  localparam int TOTAL_W  = 32;

  typedef logic [SEQ_WIDTH-1:0] seq_t;
  typedef logic [EXT_IDX_W-1:0] ext_idx_t;
  typedef logic [EXT_CNT_W-1:0] ext_cnt_t;
  typedef logic [SP_IDX_W-1:0]  sp_idx_t;
  typedef logic [SP_CNT_W-1:0]  sp_cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_SAVEPOINT = 3'd1,
    CMD_ROLLBACK  = 3'd2,
    CMD_FIND      = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_ORDER     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_UPDATE = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;  // capture the accepted word
    logic search;   // register the compare results
    logic commit;   // apply the update and load the output register
  } ctl_cmd_t;

endpackage

@@ src/lest_if.sv @@
// Valid/ready channel interfaces for the log extent savepoint tracker.
// Depends on lest_pkg.
interface lest_in_if import lest_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SEQ_IN_W-1:0] seq;

  modport source (output valid, cmd, seq, input ready);
  modport sink   (input valid, cmd, seq, output ready);
endinterface

interface lest_out_if import lest_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FOUND_W-1:0]  found_index;
  logic [INUSE_W-1:0]  extents_in_use;
  logic [INUSE_W-1:0]  savepoints_in_use;
  logic [TOTAL_W-1:0]  rollbacks_done;

  modport source (output valid, status, found_index, extents_in_use,
                  savepoints_in_use, rollbacks_done, input ready);
  modport sink   (input valid, status, found_index, extents_in_use,
                  savepoints_in_use, rollbacks_done, output ready);
endinterface

@@ src/log_extent_savepoint_tracker.sv @@
// Top level of the log extent savepoint tracker: controller plus datapath.
// Depends on lest_pkg, lest_if, lest_ctrl and lest_dp.
//
//   channel  | dir | fields
//   ---------+-----+-------------------------------------------------------
//   in_ch    | in  | cmd, seq
//   out_ch   | out | status, found_index, extents_in_use, savepoints_in_use,
//            |     | rollbacks_done
//
// Each word passes a search state, comparing seq against all extents and savepoints
// in parallel, then an update state, updating the stores and the output register.
// A new word is accepted in the update state, while the last word's update commits.
// The update state stalls while the output register holds a result not yet taken.
// Reset is synchronous and clears the counts, the rollback total and the control.
module log_extent_savepoint_tracker import lest_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lest_in_if.sink    in_ch,
  lest_out_if.source out_ch
);

  ctl_cmd_t ctl;

  lest_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  lest_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .cmd_in            (in_ch.cmd),
    .seq_in            (in_ch.seq),
    .status            (out_ch.status),
    .found_index       (out_ch.found_index),
    .extents_in_use    (out_ch.extents_in_use),
    .savepoints_in_use (out_ch.savepoints_in_use),
    .rollbacks_done    (out_ch.rollbacks_done)
  );

endmodule

@@ src/lest_ctrl.sv @@
// Controller for the log extent savepoint tracker: accept, search, update.
// Depends on lest_pkg; drives the datapath through ctl_cmd_t.
module lest_ctrl import lest_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t ctl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    ctl         = '0;
    in_ready    = 1'b0;
    out_free    = !out_valid_r || out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        ctl.search = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the output register can take the result
        if (out_free) begin
          ctl.commit = 1'b1;
          in_ready   = 1'b1;
          state_nxt  = in_valid ? S_SEARCH : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ctl.load_in = in_valid && in_ready;

    if (ctl.commit)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/lest_dp.sv @@
// Datapath for the log extent savepoint tracker: extent and savepoint stores,
// parallel compares, update logic and the output register. Depends on lest_pkg.
module lest_dp import lest_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_cmd_t            ctl,
  input  logic [CMD_W-1:0]    cmd_in,
  input  logic [SEQ_IN_W-1:0] seq_in,
  output logic [STATUS_W-1:0] status,
  output logic [FOUND_W-1:0]  found_index,
  output logic [INUSE_W-1:0]  extents_in_use,
  output logic [INUSE_W-1:0]  savepoints_in_use,
  output logic [TOTAL_W-1:0]  rollbacks_done
);

  // Captured word
  logic [CMD_W-1:0] cmd_r;
  seq_t             seq_r;

  // Stores (no reset, read only below their counts)
  seq_t ext_first_r [MAX_EXTENTS];
  seq_t ext_last_r  [MAX_EXTENTS];
  seq_t sp_seq_r    [MAX_SAVEPOINTS];

  ext_cnt_t           ext_count_r, ext_count_nxt;
  sp_cnt_t            sp_count_r, sp_count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  // Per-entry compare results
  logic [MAX_EXTENTS-1:0]    first_le;
  logic [MAX_EXTENTS-1:0]    last_ge;
  logic [MAX_EXTENTS-1:0]    last_adj;
  logic [MAX_EXTENTS-1:0]    ext_live;
  logic [MAX_SAVEPOINTS-1:0] sp_hit;

  // Encoded search results
  logic     find_hit, sp_found;
  ext_idx_t find_idx, keep_idx, top_idx;
  sp_idx_t  sp_idx;

  // Registered search results
  logic     srch_find_hit_r, srch_sp_hit_r, srch_clip_r;
  logic     srch_top_le_r, srch_top_adj_r;
  ext_idx_t srch_find_idx_r, srch_keep_r;
  sp_idx_t  srch_sp_idx_r;

  // Update controls
  status_e  status_c;
  ext_idx_t found_c;
  logic     open_req, ext_full, sp_full;
  logic     ext_first_we, ext_last_we, sp_we;
  ext_idx_t ext_wr_idx;

  // Output register
  status_e            status_r;
  ext_idx_t           found_r;
  ext_cnt_t           ext_out_r;
  sp_cnt_t            sp_out_r;
  logic [TOTAL_W-1:0] total_out_r;

  // Input capture
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= cmd_in;
      seq_r <= SEQ_WIDTH'(seq_in);
    end
  end

  // Parallel compares against every entry
  always_comb begin
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      ext_live[i] = ext_count_r > EXT_CNT_W'(i);
      first_le[i] = ext_first_r[i] <= seq_r;
      last_ge[i]  = seq_r <= ext_last_r[i];
      last_adj[i] = {1'b0, seq_r} == ({1'b0, ext_last_r[i]} + 1'b1);
    end
    for (int j = 0; j < MAX_SAVEPOINTS; j++) begin
      sp_hit[j] = (sp_count_r > SP_CNT_W'(j)) && (sp_seq_r[j] == seq_r);
    end
  end

  // Priority encoders: lowest holding extent, highest kept extent, lowest savepoint
  always_comb begin
    find_hit = 1'b0;
    find_idx = '0;
    for (int i = MAX_EXTENTS - 1; i >= 0; i--) begin
      if (ext_live[i] && first_le[i] && last_ge[i]) begin
        find_hit = 1'b1;
        find_idx = EXT_IDX_W'(i);
      end
    end
    keep_idx = '0;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      if (ext_live[i] && first_le[i]) keep_idx = EXT_IDX_W'(i);
    end
    sp_found = 1'b0;
    sp_idx   = '0;
    for (int j = MAX_SAVEPOINTS - 1; j >= 0; j--) begin
      if (sp_hit[j]) begin
        sp_found = 1'b1;
        sp_idx   = SP_IDX_W'(j);
      end
    end
  end

  assign top_idx = EXT_IDX_W'(ext_count_r - 1'b1);

  // Search stage register
  always_ff @(posedge clk) begin
    if (ctl.search) begin
      srch_find_hit_r <= find_hit;
      srch_find_idx_r <= find_idx;
      srch_keep_r     <= keep_idx;
      // clip when the kept extent ends at or past the savepoint
      srch_clip_r     <= last_ge[keep_idx];
      srch_sp_hit_r   <= sp_found;
      srch_sp_idx_r   <= sp_idx;
      srch_top_le_r   <= last_ge[top_idx];
      srch_top_adj_r  <= last_adj[top_idx];
    end
  end

  assign ext_full = ext_count_r >= EXT_CNT_W'(MAX_EXTENTS);
  assign sp_full  = sp_count_r >= SP_CNT_W'(MAX_SAVEPOINTS);

  // Update decision
  always_comb begin
    status_c      = ST_OK;
    found_c       = '0;
    open_req      = 1'b0;
    ext_first_we  = 1'b0;
    ext_last_we   = 1'b0;
    ext_wr_idx    = '0;
    sp_we         = 1'b0;
    ext_count_nxt = ext_count_r;
    sp_count_nxt  = sp_count_r;
    total_nxt     = total_r;
    case (cmd_r)
      CMD_APPEND: begin
        if (seq_r == '0) begin
          if (ext_count_r != '0) status_c = ST_ORDER;
          else                   open_req = 1'b1;
        end else if (ext_count_r == '0) begin
          status_c = ST_ORDER;
        end else if (srch_top_le_r) begin
          status_c = ST_ORDER;
        end else if (srch_top_adj_r) begin
          // extend the last extent
          ext_last_we = 1'b1;
          ext_wr_idx  = top_idx;
        end else begin
          open_req = 1'b1;
        end
        if (open_req) begin
          if (ext_full) begin
            status_c = ST_FULL;
          end else begin
            ext_first_we  = 1'b1;
            ext_last_we   = 1'b1;
            ext_wr_idx    = ext_count_r[EXT_IDX_W-1:0];
            ext_count_nxt = ext_count_r + 1'b1;
          end
        end
      end
      CMD_SAVEPOINT: begin
        // a savepoint already stored is a no-op
        if (!srch_sp_hit_r) begin
          if (sp_full) begin
            status_c = ST_FULL;
          end else begin
            sp_we        = 1'b1;
            sp_count_nxt = sp_count_r + 1'b1;
          end
        end
      end
      CMD_ROLLBACK: begin
        if (!srch_sp_hit_r) begin
          status_c = ST_NOT_FOUND;
        end else begin
          if (ext_count_r != '0) begin
            if (srch_clip_r) begin
              ext_last_we = 1'b1;
              ext_wr_idx  = srch_keep_r;
            end
            ext_count_nxt = EXT_CNT_W'(srch_keep_r) + 1'b1;
          end
          sp_count_nxt = SP_CNT_W'(srch_sp_idx_r) + 1'b1;
          total_nxt    = total_r + 1'b1;
        end
      end
      CMD_FIND: begin
        if (srch_find_hit_r) found_c  = srch_find_idx_r;
        else                 status_c = ST_NOT_FOUND;
      end
      CMD_CLEAR: begin
        ext_count_nxt = '0;
        sp_count_nxt  = '0;
        total_nxt     = '0;
      end
      default: ;
    endcase
  end

  // Store writes
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (ext_first_we) ext_first_r[ext_wr_idx] <= seq_r;
      if (ext_last_we)  ext_last_r[ext_wr_idx]  <= seq_r;
      if (sp_we)        sp_seq_r[sp_count_r[SP_IDX_W-1:0]] <= seq_r;
    end
  end

  // Counts and rollback total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_count_r <= '0;
      sp_count_r  <= '0;
      total_r     <= '0;
    end else if (ctl.commit) begin
      ext_count_r <= ext_count_nxt;
      sp_count_r  <= sp_count_nxt;
      total_r     <= total_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status_r    <= status_c;
      found_r     <= found_c;
      ext_out_r   <= ext_count_nxt;
      sp_out_r    <= sp_count_nxt;
      total_out_r <= total_nxt;
    end
  end

  assign status            = status_r;
  assign found_index       = FOUND_W'(found_r);
  assign extents_in_use    = INUSE_W'(ext_out_r);
  assign savepoints_in_use = INUSE_W'(sp_out_r);
  assign rollbacks_done    = total_out_r;

endmodule

@@ src/lest_chk.sv @@
// Port-level checker for the log extent savepoint tracker, bound to the top.
// Depends on lest_pkg and log_extent_savepoint_tracker_assert.svh.
`include "log_extent_savepoint_tracker_assert.svh"

module lest_chk import lest_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [FOUND_W-1:0]  found_index,
  input logic [INUSE_W-1:0]  extents_in_use,
  input logic [INUSE_W-1:0]  savepoints_in_use,
  input logic [TOTAL_W-1:0]  rollbacks_done
);

  logic [STATUS_W+FOUND_W+2*INUSE_W+TOTAL_W-1:0] out_word;
  logic in_acc, out_stall, counts_ok, found_ok;

  assign out_word  = {status, found_index, extents_in_use, savepoints_in_use, rollbacks_done};
  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign counts_ok = (extents_in_use <= INUSE_W'(MAX_EXTENTS)) &&
                     (savepoints_in_use <= INUSE_W'(MAX_SAVEPOINTS));
  assign found_ok  = (found_index == '0) || (status == ST_OK);

  // A stalled result word stays up and unchanged
  `LEST_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word))
  // A fresh result follows an accepted word after search and update
  `LEST_ASSERT_SAME(a_out_latency, $rose(out_valid), $past(in_acc, 3))
  // Counts never exceed the store depths
  `LEST_ASSERT_SAME(a_counts, out_valid, counts_ok)
  // A nonzero found index only comes with an ok status
  `LEST_ASSERT_SAME(a_found, out_valid, found_ok)

endmodule

bind log_extent_savepoint_tracker lest_chk u_lest_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .status            (out_ch.status),
  .found_index       (out_ch.found_index),
  .extents_in_use    (out_ch.extents_in_use),
  .savepoints_in_use (out_ch.savepoints_in_use),
  .rollbacks_done    (out_ch.rollbacks_done)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for log_extent_savepoint_tracker: random and directed command words.
// A local shadow of the extent and savepoint lists predicts every report word.
// Depends on lest_pkg, lest_if and the tracker RTL.
module tb import lest_pkg::*;;

  localparam int RANDOM_WORDS = 1425;
  localparam int IDLE_PCT     = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [SEQ_IN_W-1:0] SEQ_TOP = '1;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SEQ_IN_W-1:0] seq;
  } cmd_word_t;

  typedef struct packed {
    status_e             status;
    logic [FOUND_W-1:0]  found_index;
    logic [INUSE_W-1:0]  extents;
    logic [INUSE_W-1:0]  savepoints;
    logic [TOTAL_W-1:0]  rollbacks;
  } report_t;

  logic clk;
  logic rst_n;

  lest_in_if  in_ch ();
  lest_out_if out_ch ();

  log_extent_savepoint_tracker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cmd_word_t pending_cmds[$];
  report_t   expected_reports[$];

  // Shadow of the tracker stores
  seq_t              shadow_first[MAX_EXTENTS];
  seq_t              shadow_last[MAX_EXTENTS];
  int                shadow_ext_cnt;
  seq_t              shadow_sp[MAX_SAVEPOINTS];
  int                shadow_sp_cnt;
  logic [TOTAL_W-1:0] shadow_rollbacks;

  int err_cnt;
  int n_sent;
  int n_recv;
  int cmd_hist[8];
  int status_hist[4];
  int hold_left;
  bit held;

  // Apply one command to the shadow stores and return the report it yields
  function automatic report_t track_cmd(logic [CMD_W-1:0] cmd, logic [SEQ_IN_W-1:0] seq_in);
    report_t r;
    seq_t    s;
    int      top;
    int      sp_hit;
    int      keep;
    s        = seq_t'(seq_in);
    r        = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_APPEND: begin
        top = shadow_ext_cnt - 1;
        if (s == '0 && shadow_ext_cnt != 0) begin
          r.status = ST_ORDER;
        end else if (s != '0 && shadow_ext_cnt == 0) begin
          r.status = ST_ORDER;
        end else if (s != '0 && s <= shadow_last[top]) begin
          r.status = ST_ORDER;
        end else if (s != '0 && {1'b0, s} == {1'b0, shadow_last[top]} + 1) begin
          shadow_last[top] = s;
        end else if (shadow_ext_cnt >= MAX_EXTENTS) begin
          r.status = ST_FULL;
        end else begin
          shadow_first[shadow_ext_cnt] = s;
          shadow_last[shadow_ext_cnt]  = s;
          shadow_ext_cnt++;
        end
      end
      CMD_SAVEPOINT, CMD_ROLLBACK: begin
        sp_hit = -1;
        for (int i = shadow_sp_cnt - 1; i >= 0; i--)
          if (shadow_sp[i] == s) sp_hit = i;
        if (cmd == CMD_SAVEPOINT) begin
          if (sp_hit < 0) begin
            if (shadow_sp_cnt >= MAX_SAVEPOINTS) begin
              r.status = ST_FULL;
            end else begin
              shadow_sp[shadow_sp_cnt] = s;
              shadow_sp_cnt++;
            end
          end
        end else if (sp_hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // keep the highest extent starting at or below the savepoint
          if (shadow_ext_cnt != 0) begin
            keep = 0;
            for (int i = 0; i < shadow_ext_cnt; i++)
              if (shadow_first[i] <= s) keep = i;
            if (shadow_last[keep] > s) shadow_last[keep] = s;
            shadow_ext_cnt = keep + 1;
          end
          shadow_sp_cnt = sp_hit + 1;
          shadow_rollbacks++;
        end
      end
      CMD_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int i = shadow_ext_cnt - 1; i >= 0; i--) begin
          if (shadow_first[i] <= s && s <= shadow_last[i]) begin
            r.status      = ST_OK;
            r.found_index = i[FOUND_W-1:0];
          end
        end
      end
      CMD_CLEAR: begin
        shadow_ext_cnt   = 0;
        shadow_sp_cnt    = 0;
        shadow_rollbacks = '0;
      end
      default: ;
    endcase
    r.extents    = shadow_ext_cnt[INUSE_W-1:0];
    r.savepoints = shadow_sp_cnt[INUSE_W-1:0];
    r.rollbacks  = shadow_rollbacks;
    return r;
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [SEQ_IN_W-1:0] seq_in);
    cmd_word_t w;
    w.cmd = cmd;
    w.seq = seq_in;
    pending_cmds.push_back(w);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Command stream: directed corner cases, then random transaction sessions
  initial begin : fill_stimulus
    logic [SEQ_IN_W-1:0] last_seq;
    logic [SEQ_IN_W-1:0] v;
    logic [SEQ_IN_W-1:0] step;
    logic [SEQ_IN_W-1:0] room;
    logic [SEQ_IN_W-1:0] sp_pool[$];
    bit                  have_ext;
    bit                  fill_mode;
    bit                  dup;
    int                  r;
    int                  pick;
    int                  idx;

    queue_cmd(CMD_FIND, 0);            // empty store
    queue_cmd(CMD_ROLLBACK, 3);        // savepoint never stored
    queue_cmd(CMD_APPEND, 5);          // nonzero on empty store
    queue_cmd(CMD_APPEND, 0);
    queue_cmd(CMD_APPEND, 0);          // zero with extents present
    queue_cmd(CMD_APPEND, 1);          // extends extent 0
    queue_cmd(CMD_SAVEPOINT, 1);
    queue_cmd(CMD_SAVEPOINT, 1);       // already stored
    queue_cmd(CMD_APPEND, 1);          // at the last end
    queue_cmd(CMD_APPEND, 10);         // gap opens a new extent
    queue_cmd(CMD_APPEND, 11);
    queue_cmd(CMD_SAVEPOINT, 11);
    queue_cmd(CMD_APPEND, SEQ_TOP);
    queue_cmd(CMD_FIND, 10);
    queue_cmd(CMD_FIND, SEQ_TOP);
    queue_cmd(CMD_FIND, 5);            // falls in a gap
    queue_cmd(CMD_ROLLBACK, 11);
    queue_cmd(CMD_ROLLBACK, 1);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      queue_cmd(c[CMD_W-1:0], SEQ_TOP);
    queue_cmd(CMD_CLEAR, 0);
    queue_cmd(CMD_SAVEPOINT, 7);
    queue_cmd(CMD_ROLLBACK, 7);        // rollback with no extents
    queue_cmd(CMD_FIND, 0);

    // fill mode favors gaps and savepoints so that both lists run full
    queue_cmd(CMD_CLEAR, $urandom);
    have_ext  = 1'b0;
    last_seq  = '0;
    fill_mode = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      r    = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: any code, any value
        queue_cmd(CMD_W'($urandom_range(0, CMD_SPARE_LAST)), $urandom);
      end else if (r < (fill_mode ? 9 : 11)) begin
        queue_cmd(CMD_CLEAR, $urandom);
        have_ext  = 1'b0;
        sp_pool.delete();
        fill_mode = ($urandom_range(0, 2) == 0);
      end else if (r < 50) begin
        if (!have_ext) begin
          if (pick < 10) begin
            queue_cmd(CMD_APPEND, $urandom | 1);
          end else begin
            queue_cmd(CMD_APPEND, 0);
            have_ext = 1'b1;
            last_seq = '0;
          end
        end else if (pick < 8) begin
          queue_cmd(CMD_APPEND, $urandom_range(0, last_seq));
        end else begin
          room = SEQ_TOP - last_seq;
          if (room == 0) begin
            queue_cmd(CMD_CLEAR, $urandom);
            have_ext = 1'b0;
            sp_pool.delete();
          end else begin
            if (pick < (fill_mode ? 40 : 85)) step = 1;
            else if (pick < 97) step = $urandom_range(2, 5000);
            else step = $urandom | 1;
            if (step > room) step = room;
            last_seq += step;
            queue_cmd(CMD_APPEND, last_seq);
          end
        end
      end else if (r < (fill_mode ? 74 : 65)) begin
        if (sp_pool.size() != 0 && pick < 15) v = sp_pool[$urandom_range(0, sp_pool.size() - 1)];
        else if (have_ext && pick < 92) v = last_seq;
        else v = $urandom;
        queue_cmd(CMD_SAVEPOINT, v);
        dup = 1'b0;
        foreach (sp_pool[i]) if (sp_pool[i] == v) dup = 1'b1;
        if (!dup) sp_pool.push_back(v);
      end else if (r < (fill_mode ? 77 : 80)) begin
        if (sp_pool.size() != 0 && pick < 85) begin
          idx = $urandom_range(0, sp_pool.size() - 1);
          v   = sp_pool[idx];
          while (sp_pool.size() > idx + 1) void'(sp_pool.pop_back());
          if (have_ext && v < last_seq) last_seq = v;
        end else begin
          v = $urandom;
        end
        queue_cmd(CMD_ROLLBACK, v);
      end else begin
        if (have_ext && pick < 75) v = $urandom_range(0, last_seq);
        else if (pick < 88) v = last_seq + 1;
        else v = $urandom;
        queue_cmd(CMD_FIND, v);
      end
    end
  end

  // Driver: offers queued words, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd   <= '0;
      in_ch.seq   <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_reports.push_back(track_cmd(in_ch.cmd, in_ch.seq));
        cmd_hist[in_ch.cmd]++;
        n_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 &&
            ((n_sent >= 700 && n_sent < 1000) || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_ch.valid <= 1'b1;
          in_ch.cmd   <= pending_cmds[0].cmd;
          in_ch.seq   <= pending_cmds[0].seq;
          void'(pending_cmds.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks report words in order, throttles ready
  always @(posedge clk) begin
    report_t want;
    report_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status      = status_e'(out_ch.status);
        got.found_index = out_ch.found_index;
        got.extents     = out_ch.extents_in_use;
        got.savepoints  = out_ch.savepoints_in_use;
        got.rollbacks   = out_ch.rollbacks_done;
        status_hist[got.status]++;
        n_recv++;
        if (expected_reports.size() == 0) begin
          $display("%0t: report word with no command outstanding", $time);
          err_cnt++;
        end else begin
          want = expected_reports.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            err_cnt++;
          end
          if (got.found_index != want.found_index) begin
            $display("%0t: found_index expected %0d, got %0d", $time,
                     want.found_index, got.found_index);
            err_cnt++;
          end
          if (got.extents != want.extents) begin
            $display("%0t: extents_in_use expected %0d, got %0d", $time,
                     want.extents, got.extents);
            err_cnt++;
          end
          if (got.savepoints != want.savepoints) begin
            $display("%0t: savepoints_in_use expected %0d, got %0d", $time,
                     want.savepoints, got.savepoints);
            err_cnt++;
          end
          if (got.rollbacks != want.rollbacks) begin
            $display("%0t: rollbacks_done expected %0d, got %0d", $time,
                     want.rollbacks, got.rollbacks);
            err_cnt++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!held && n_recv >= 400) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (n_recv >= 700 && n_recv < 1000) || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // Reset, drain and verdict
  initial begin : run_ctrl
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d words: append %0d, savepoint %0d, rollback %0d, find %0d, clear %0d",
             n_sent, cmd_hist[CMD_APPEND], cmd_hist[CMD_SAVEPOINT], cmd_hist[CMD_ROLLBACK],
             cmd_hist[CMD_FIND], cmd_hist[CMD_CLEAR]);
    $display("reports: ok %0d, not found %0d, out of order %0d, list full %0d; mismatches %0d",
             status_hist[ST_OK], status_hist[ST_NOT_FOUND], status_hist[ST_ORDER],
             status_hist[ST_FULL], err_cnt);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d reports still outstanding", $time, expected_reports.size());
    $display("tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/lest_pkg.sv
src/lest_if.sv
src/lest_ctrl.sv
src/lest_dp.sv
src/log_extent_savepoint_tracker.sv
src/lest_chk.sv
tb/sv/tb.sv
